>>> rtl/core/stpd_pkg.sv
// shared constants, types and elaboration-time coefficient rom for the true-peak detector
package stpd_pkg;

  localparam int OVERSAMPLE     = 4;
  localparam int TAPS_PER_PHASE = 12;
  localparam int COEF_BITS      = 18;

  localparam int FULL_TAPS = OVERSAMPLE * TAPS_PER_PHASE;
  localparam int COEF_FRAC = COEF_BITS - 2;
  localparam int SAMPLE_W  = 24;
  localparam int PEAK_W    = 25;
  localparam int PROD_W    = SAMPLE_W + COEF_BITS;
  localparam int ACC_W     = PROD_W + $clog2(TAPS_PER_PHASE);
  localparam int TP_W      = $clog2(TAPS_PER_PHASE);
  localparam int ADDR_W    = $clog2(FULL_TAPS);

  localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

  localparam longint Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] PI_Q28 = 64'd843314857;
  localparam longint WIN_A0     = 64'd450971566;
  localparam longint WIN_A1     = 64'd536870912;
  localparam longint WIN_A2     = 64'd85899346;
  localparam logic [63:0] NORM_FLOOR = 64'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } stpd_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } stpd_cmd_t;

  typedef struct packed {
    logic last_issue;
    logic pipe_busy;
  } stpd_status_t;

  // shift-subtract division, only evaluated while building the rom
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mag(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // sin(pi*a/q) in q30, taylor series to theta^15
  function automatic longint sin_pi(input logic [63:0] a, input logic [63:0] q);
    logic [63:0] r;
    logic [63:0] theta;
    logic [63:0] t;
    longint      s;
    logic        neg;
    r   = a - udiv(a, 2 * q) * (2 * q);
    neg = 1'b0;
    if (r >= q) begin
      neg = 1'b1;
      r   = r - q;
    end
    if (2 * r > q) r = q - r;
    theta = udiv(PI_Q30 * r, q);
    t     = theta;
    s     = longint'(theta);
    for (int k = 1; k <= 7; k++) begin
      t = (t * theta) >> 30;
      t = (t * theta) >> 30;
      t = udiv(t, 64'((2 * k) * (2 * k + 1)));
      if (k[0]) s = s - longint'(t);
      else s = s + longint'(t);
    end
    return neg ? -s : s;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    logic [63:0] m;
    logic        neg;
    m   = (mag(a) * mag(b)) >> 30;
    neg = (a < 0) != (b < 0);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sinc_q30(input longint p, input logic [63:0] q);
    logic [63:0] a;
    logic [63:0] num;
    logic [63:0] v;
    longint      s;
    if (p == 0) return Q30_ONE;
    a   = mag(p);
    s   = sin_pi(a, q);
    num = (mag(s) * q) << 28;
    v   = udiv(num, PI_Q28 * a);
    return (s < 0) ? -longint'(v) : longint'(v);
  endfunction

  // blackman-windowed sinc split into phases, unity gain per phase
  // entry ph*TAPS_PER_PHASE+tp sits at bits [entry*COEF_BITS +: COEF_BITS]
  function automatic logic [FULL_TAPS*COEF_BITS-1:0] build_coef_rom();
    logic [FULL_TAPS*COEF_BITS-1:0] rom;
    longint      raw [TAPS_PER_PHASE];
    longint      sum;
    longint      s;
    longint      c1;
    longint      c2;
    longint      w;
    longint      c;
    logic [63:0] m;
    logic [63:0] n;
    logic [63:0] smag;
    logic [63:0] cm;
    logic [63:0] cmax;
    logic        neg;
    rom  = '0;
    m    = 64'(FULL_TAPS - 1);
    cmax = (64'd1 << (COEF_BITS - 1)) - 64'd1;
    for (int ph = 0; ph < OVERSAMPLE; ph++) begin
      sum = 0;
      for (int tp = 0; tp < TAPS_PER_PHASE; tp++) begin
        n       = 64'(tp * OVERSAMPLE + ph);
        s       = sinc_q30(longint'(2 * n) - longint'(m), 64'(2 * OVERSAMPLE));
        c1      = sin_pi(4 * n + m, 2 * m);
        c2      = sin_pi(8 * n + m, 2 * m);
        w       = WIN_A0 - mul_q30(WIN_A1, c1) + mul_q30(WIN_A2, c2);
        raw[tp] = mul_q30(s, w);
        sum     = sum + raw[tp];
      end
      smag = mag(sum);
      for (int tp = 0; tp < TAPS_PER_PHASE; tp++) begin
        if (smag > NORM_FLOOR) begin
          cm  = udiv((mag(raw[tp]) << COEF_FRAC) + (smag >> 1), smag);
          neg = (raw[tp] < 0) != (sum < 0);
        end else begin
          cm  = (mag(raw[tp]) + (64'd1 << (29 - COEF_FRAC))) >> (30 - COEF_FRAC);
          neg = raw[tp] < 0;
        end
        if (neg) begin
          if (cm > cmax + 64'd1) cm = cmax + 64'd1;
          c = -longint'(cm);
        end else begin
          if (cm > cmax) cm = cmax;
          c = longint'(cm);
        end
        rom[(ph * TAPS_PER_PHASE + tp) * COEF_BITS +: COEF_BITS] = COEF_BITS'(c);
      end
    end
    return rom;
  endfunction

endpackage

>>> rtl/core/stpd_ctrl.sv
// sequencing state machine and output valid for the true-peak detector
module stpd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  stpd_pkg::stpd_status_t status_i,
  output stpd_pkg::stpd_cmd_t    cmd_o
);
  import stpd_pkg::*;

  stpd_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (status_i.last_issue) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // wait for the mac pipe and a free output register
        if (!status_i.pipe_busy && (!out_valid_q || !out_stall_i)) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/stpd_datapath.sv
// sample histories, polyphase multiply-accumulate pipe and peak tracking
module stpd_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  stpd_pkg::stpd_cmd_t                   cmd_i,
  output stpd_pkg::stpd_status_t                status_o,
  input  logic signed [stpd_pkg::SAMPLE_W-1:0]  left_sample_i,
  input  logic signed [stpd_pkg::SAMPLE_W-1:0]  right_sample_i,
  output logic        [stpd_pkg::PEAK_W-1:0]    true_peak_o
);
  import stpd_pkg::*;

  localparam logic [FULL_TAPS*COEF_BITS-1:0] COEF_ROM = build_coef_rom();
  localparam logic [TP_W-1:0]   TP_LAST   = TP_W'(TAPS_PER_PHASE - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(FULL_TAPS - 1);

  logic signed [SAMPLE_W-1:0] hist_l_q [TAPS_PER_PHASE];
  logic signed [SAMPLE_W-1:0] hist_r_q [TAPS_PER_PHASE];

  logic [TP_W-1:0]   wp_q, wp_d;
  logic [TP_W-1:0]   rd_idx_q, rd_idx_d;
  logic [TP_W-1:0]   tp_q, tp_d;
  logic [ADDR_W-1:0] addr_q, addr_d;

  logic                     prod_vld_q, first_p_q, last_p_q;
  logic signed [PROD_W-1:0] prod_l_q, prod_r_q;
  logic                     acc_vld_q;
  logic signed [ACC_W-1:0]  acc_l_q, acc_r_q;
  logic [PEAK_W-1:0]        peak_q, peak_d;
  logic [PEAK_W-1:0]        true_peak_q;

  logic signed [COEF_BITS-1:0] coef;
  logic [PEAK_W-1:0]           mag_l, mag_r, pk_l, pk_r;

  // magnitude rounded half up from q(23+frac) to q23, saturated
  function automatic logic [PEAK_W-1:0] to_peak(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] m;
    logic [ACC_W:0]   rnd;
    m   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    rnd = ({1'b0, m} + ((ACC_W + 1)'(1) << (COEF_FRAC - 1))) >> COEF_FRAC;
    return (rnd > (ACC_W + 1)'(PEAK_MAX)) ? PEAK_MAX : rnd[PEAK_W-1:0];
  endfunction

  assign coef  = COEF_ROM[addr_q * COEF_BITS +: COEF_BITS];
  assign mag_l = left_sample_i[SAMPLE_W-1] ? PEAK_W'(-PEAK_W'(left_sample_i))
                                           : PEAK_W'(left_sample_i);
  assign mag_r = right_sample_i[SAMPLE_W-1] ? PEAK_W'(-PEAK_W'(right_sample_i))
                                            : PEAK_W'(right_sample_i);
  assign pk_l  = to_peak(acc_l_q);
  assign pk_r  = to_peak(acc_r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS_PER_PHASE; i++) begin
        hist_l_q[i] <= '0;
        hist_r_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      hist_l_q[wp_q] <= left_sample_i;
      hist_r_q[wp_q] <= right_sample_i;
    end
  end

  // tap walk: newest sample first, coefficient address runs phase by phase
  always_comb begin
    wp_d     = wp_q;
    rd_idx_d = rd_idx_q;
    tp_d     = tp_q;
    addr_d   = addr_q;
    if (cmd_i.load) begin
      rd_idx_d = wp_q;
      tp_d     = '0;
      addr_d   = '0;
    end else if (cmd_i.step) begin
      addr_d = addr_q + ADDR_W'(1);
      if (tp_q == TP_LAST) begin
        tp_d     = '0;
        rd_idx_d = wp_q;
      end else begin
        tp_d     = tp_q + TP_W'(1);
        rd_idx_d = (rd_idx_q == '0) ? TP_LAST : rd_idx_q - TP_W'(1);
      end
    end
    if (cmd_i.finish) wp_d = (wp_q == TP_LAST) ? '0 : wp_q + TP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rd_idx_q   <= '0;
      tp_q       <= '0;
      addr_q     <= '0;
      prod_vld_q <= 1'b0;
      acc_vld_q  <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      rd_idx_q   <= rd_idx_d;
      tp_q       <= tp_d;
      addr_q     <= addr_d;
      prod_vld_q <= cmd_i.step;
      acc_vld_q  <= prod_vld_q && last_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      prod_l_q  <= hist_l_q[rd_idx_q] * coef;
      prod_r_q  <= hist_r_q[rd_idx_q] * coef;
      first_p_q <= (tp_q == '0);
      last_p_q  <= (tp_q == TP_LAST);
    end
    if (prod_vld_q) begin
      acc_l_q <= (first_p_q ? '0 : acc_l_q) + ACC_W'(prod_l_q);
      acc_r_q <= (first_p_q ? '0 : acc_r_q) + ACC_W'(prod_r_q);
    end
    peak_q <= peak_d;
    if (cmd_i.finish) true_peak_q <= peak_q;
  end

  always_comb begin
    peak_d = peak_q;
    if (cmd_i.load) begin
      peak_d = (mag_r > mag_l) ? mag_r : mag_l;
    end else if (acc_vld_q) begin
      if (pk_l > peak_d) peak_d = pk_l;
      if (pk_r > peak_d) peak_d = pk_r;
    end
  end

  assign status_o.last_issue = cmd_i.step && (addr_q == ADDR_LAST);
  assign status_o.pipe_busy  = prod_vld_q || acc_vld_q;
  assign true_peak_o         = true_peak_q;

endmodule

>>> rtl/core/stereo_true_peak_detector_core.sv
// top level of the stereo true-peak detector
// Each stereo pair is written into a 12-deep history per channel, then all four
// polyphase branches of a 48-tap blackman-windowed sinc interpolator are run over
// both histories, one tap of both channels per cycle through a pair of 24x18
// multipliers. The result is the largest of the two input magnitudes and the
// eight interpolated magnitudes, saturated to 25 bits unsigned Q2.23. Each item
// is accepted, run through the multiply-accumulate steps of all 48 taps, and
// then the multiply and round/compare stages are emptied and the output
// register is loaded; the result shows on true_peak_o the cycle after. No new
// item is taken until the output register is loaded. A result that waits in the
// output register does not hold off the next transaction on the input side, only
// the loading of the following result. Histories are zero after reset.
module stereo_true_peak_detector_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [stpd_pkg::SAMPLE_W-1:0] left_sample_i,
  input  logic signed [stpd_pkg::SAMPLE_W-1:0] right_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [stpd_pkg::PEAK_W-1:0]   true_peak_o
);
  import stpd_pkg::*;

  stpd_cmd_t    cmd;
  stpd_status_t status;

  stpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stpd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .true_peak_o    (true_peak_o)
  );

endmodule

>>> rtl/core/stpd_checker.sv
// port-level assertions for the true-peak detector, bound to the top level
module stpd_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic signed [stpd_pkg::SAMPLE_W-1:0] left_sample_i,
  input logic signed [stpd_pkg::SAMPLE_W-1:0] right_sample_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic        [stpd_pkg::PEAK_W-1:0]   true_peak_o
);
  import stpd_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled input transaction keeps its samples
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(left_sample_i) && $stable(right_sample_i))
    else $error("stalled input changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(true_peak_o))
    else $error("stalled result changed");

  // the input stays busy after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o ##1 in_stall_o)
    else $error("input taken again too soon");

  // a new result only appears at the end of a computation
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a computation");

  // no result straight after a transaction is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result too early");

endmodule

bind stereo_true_peak_detector_core stpd_checker u_stpd_checker (.*);

>>> dv/testbench.sv
// self-checking testbench for the stereo true-peak detector core
`timescale 1ns / 100ps

module testbench;

  localparam int NPH      = stpd_pkg::OVERSAMPLE;
  localparam int NTAP     = stpd_pkg::TAPS_PER_PHASE;
  localparam int CBITS    = stpd_pkg::COEF_BITS;
  localparam int CFRAC    = CBITS - 2;
  localparam int SW       = stpd_pkg::SAMPLE_W;
  localparam int PW       = stpd_pkg::PEAK_W;
  localparam int N_RANDOM = 2000;
  localparam int LIMIT    = 1000000;
  localparam int HOLD_LEN = 400;

  localparam bit [63:0] PI_Q30_C   = 64'd3373259426;
  localparam bit [63:0] PI_Q28_C   = 64'd843314857;
  localparam longint    ONE_Q30    = 64'd1073741824;
  localparam longint    BLK_A0     = 64'd450971566;
  localparam longint    BLK_A1     = 64'd536870912;
  localparam longint    BLK_A2     = 64'd85899346;
  localparam bit [63:0] GAIN_FLOOR = 64'd10;
  localparam bit [63:0] PEAK_SAT   = (64'd1 << PW) - 64'd1;

  localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SW-1:0] S_MIN = 24'sh800000;

  typedef struct {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } stereo_pair_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic signed [SW-1:0] left_sample_i  = '0;
  logic signed [SW-1:0] right_sample_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic        [PW-1:0] true_peak_o;

  logic rx_stall = 1'b0;
  logic hold_off = 1'b0;
  assign out_stall_i = rx_stall | hold_off;

  stereo_true_peak_detector_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .true_peak_o    (true_peak_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  longint               coef_rom   [NPH][NTAP];
  logic signed [SW-1:0] left_hist  [NTAP];
  logic signed [SW-1:0] right_hist [NTAP];
  int                   wr_pos;

  stereo_pair_t    pending_pairs[$];
  logic [PW-1:0]   expected_peaks[$];
  int              mismatches = 0;
  int              peaks_seen = 0;
  int              cycles     = 0;

  function automatic bit [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // sin(pi*a/q) in q30, angle folded into the first quadrant
  function automatic longint sine_pi_q30(input bit [63:0] a, input bit [63:0] q);
    bit [63:0] r;
    bit [63:0] theta;
    bit [63:0] t;
    longint    acc;
    bit        neg;
    r   = a % (2 * q);
    neg = 1'b0;
    if (r >= q) begin
      neg = 1'b1;
      r   = r - q;
    end
    if (2 * r > q) r = q - r;
    theta = (PI_Q30_C * r) / q;
    t     = theta;
    acc   = longint'(theta);
    for (int k = 1; k <= 7; k++) begin
      t = (t * theta) >> 30;
      t = (t * theta) >> 30;
      t = t / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    return neg ? -acc : acc;
  endfunction

  function automatic longint fixmul_q30(input longint a, input longint b);
    bit [63:0] m;
    m = (abs64(a) * abs64(b)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sinc_pi_q30(input longint p, input bit [63:0] q);
    bit [63:0] a;
    bit [63:0] v;
    longint    s;
    if (p == 0) return ONE_Q30;
    a = abs64(p);
    s = sine_pi_q30(a, q);
    v = ((abs64(s) * q) << 28) / (PI_Q28_C * a);
    return (s < 0) ? -longint'(v) : longint'(v);
  endfunction

  // blackman-windowed sinc, split per phase and normalised to unity gain
  function automatic void build_coefs();
    longint    raw [NTAP];
    longint    sum;
    longint    wnd;
    bit [63:0] m;
    bit [63:0] n;
    bit [63:0] smag;
    bit [63:0] cm;
    bit [63:0] cmax;
    bit        neg;
    m    = 64'(NPH * NTAP - 1);
    cmax = (64'd1 << (CBITS - 1)) - 64'd1;
    for (int ph = 0; ph < NPH; ph++) begin
      sum = 0;
      for (int tp = 0; tp < NTAP; tp++) begin
        n   = 64'(tp * NPH + ph);
        wnd = BLK_A0 - fixmul_q30(BLK_A1, sine_pi_q30(4 * n + m, 2 * m))
                     + fixmul_q30(BLK_A2, sine_pi_q30(8 * n + m, 2 * m));
        raw[tp] = fixmul_q30(sinc_pi_q30(longint'(2 * n) - longint'(m), 64'(2 * NPH)), wnd);
        sum     = sum + raw[tp];
      end
      smag = abs64(sum);
      for (int tp = 0; tp < NTAP; tp++) begin
        if (smag > GAIN_FLOOR) begin
          cm  = ((abs64(raw[tp]) << CFRAC) + smag / 2) / smag;
          neg = (raw[tp] < 0) != (sum < 0);
        end else begin
          cm  = (abs64(raw[tp]) + (64'd1 << (29 - CFRAC))) >> (30 - CFRAC);
          neg = raw[tp] < 0;
        end
        if (neg) begin
          if (cm > cmax + 1) cm = cmax + 1;
          coef_rom[ph][tp] = -longint'(cm);
        end else begin
          if (cm > cmax) cm = cmax;
          coef_rom[ph][tp] = longint'(cm);
        end
      end
    end
  endfunction

  // q(23+frac) accumulator magnitude rounded half up to q23, saturated
  function automatic bit [63:0] q23_magnitude(input longint acc);
    bit [63:0] m;
    m = (abs64(acc) + (64'd1 << (CFRAC - 1))) >> CFRAC;
    return (m > PEAK_SAT) ? PEAK_SAT : m;
  endfunction

  function automatic logic [PW-1:0] predict_true_peak(input logic signed [SW-1:0] l,
                                                      input logic signed [SW-1:0] r);
    bit [63:0] peak;
    bit [63:0] v;
    longint    acc_l;
    longint    acc_r;
    int        idx;
    left_hist[wr_pos]  = l;
    right_hist[wr_pos] = r;
    peak = abs64(l);
    v    = abs64(r);
    if (v > peak) peak = v;
    for (int ph = 0; ph < NPH; ph++) begin
      acc_l = 0;
      acc_r = 0;
      idx   = wr_pos;
      // newest sample meets tap zero
      for (int tp = 0; tp < NTAP; tp++) begin
        acc_l = acc_l + longint'(left_hist[idx]) * coef_rom[ph][tp];
        acc_r = acc_r + longint'(right_hist[idx]) * coef_rom[ph][tp];
        idx   = (idx == 0) ? NTAP - 1 : idx - 1;
      end
      v = q23_magnitude(acc_l);
      if (v > peak) peak = v;
      v = q23_magnitude(acc_r);
      if (v > peak) peak = v;
    end
    wr_pos = (wr_pos + 1) % NTAP;
    if (peak > PEAK_SAT) peak = PEAK_SAT;
    return peak[PW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return 24'sd1;
      3:       return -24'sd1;
      default: return '0;
    endcase
  endfunction

  task automatic queue_pair(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
    stereo_pair_t p;
    p.left  = l;
    p.right = r;
    pending_pairs.push_back(p);
  endtask

  task automatic note_mismatch(input string what, input logic [PW-1:0] want,
                               input logic [PW-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d at %0t: %s expected %0d got %0d", mismatches, $realtime, what,
               want, got);
  endtask

  // sender
  int   tx_gap  = 0;
  logic tx_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : sender
    stereo_pair_t p;
    int           gap;
    logic         fire;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap     <= 0;
    end else begin
      fire = in_valid_i && !in_stall_o;
      gap  = tx_gap;
      if (fire) begin
        expected_peaks.push_back(predict_true_peak(left_sample_i, right_sample_i));
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
      end
      if (fire || !in_valid_i) begin
        if (gap != 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          p = pending_pairs.pop_front();
          in_valid_i     <= 1'b1;
          left_sample_i  <= p.left;
          right_sample_i <= p.right;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      tx_gap <= gap;
    end
  end

  // receiver and checker
  int   rx_wait = 0;
  logic rx_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int w;
    if (!rst_ni) begin
      rx_stall   <= 1'b0;
      rx_wait    <= 0;
      peaks_seen <= 0;
    end else begin
      w = rx_wait;
      if (out_valid_o && !out_stall_i) begin
        if (expected_peaks.size() == 0) begin
          note_mismatch("unexpected true_peak transaction", '0, true_peak_o);
        end else if (expected_peaks[0] !== true_peak_o) begin
          note_mismatch("true_peak", expected_peaks.pop_front(), true_peak_o);
        end else begin
          void'(expected_peaks.pop_front());
        end
        peaks_seen <= peaks_seen + 1;
        if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        w = rx_calm ? 0 : $urandom_range(0, 3);
      end else if (out_valid_o && w != 0) begin
        w--;
      end
      rx_wait  <= w;
      rx_stall <= (w != 0);
    end
  end

  // long back-pressure so the core fills up and stalls its input
  int hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : long_hold
    if (!rst_ni) begin
      hold_left <= 0;
      hold_off  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      hold_off  <= (hold_left != 1);
    end else if (out_valid_o && !out_stall_i && (peaks_seen == 40 || peaks_seen == 1200)) begin
      hold_left <= HOLD_LEN;
      hold_off  <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [SW-1:0] l;
    logic signed [SW-1:0] r;
    logic signed [SW-1:0] big;
    int                   mode;
    int                   ph;
    int                   tp;
    int                   n_items;

    build_coefs();
    for (int i = 0; i < NTAP; i++) begin
      left_hist[i]  = '0;
      right_hist[i] = '0;
    end
    wr_pos = 0;

    // directed: extremes, most negative input, bit patterns
    queue_pair('0, '0);
    queue_pair(S_MAX, S_MAX);
    queue_pair(S_MIN, S_MIN);
    queue_pair(S_MAX, S_MIN);
    queue_pair(S_MIN, S_MAX);
    queue_pair(24'sd1, -24'sd1);
    queue_pair(24'sh555555, 24'shAAAAAA);
    queue_pair(24'shAAAAAA, 24'sh555555);
    // worst-case overshoot: full scale with the signs of one phase's taps
    ph = NPH / 2;
    for (int j = 0; j < NTAP; j++) begin
      tp = NTAP - 1 - j;
      if (coef_rom[ph][tp] >= 0) queue_pair(S_MAX, S_MIN);
      else queue_pair(S_MIN, S_MAX);
    end
    queue_pair('0, '0);

    n_items = 0;
    while (n_items < N_RANDOM) begin
      mode = $urandom_range(0, 5);
      ph   = $urandom_range(0, NPH - 1);
      big  = S_MAX >>> $urandom_range(0, 3);
      for (int j = 0; j < 16; j++) begin
        case (mode)
          0: begin
            l = 24'($urandom);
            r = 24'($urandom);
          end
          1: begin
            // near full-scale sign alternation
            l = S_MAX - 24'($urandom_range(0, 65535));
            r = S_MAX - 24'($urandom_range(0, 65535));
            if (j % 2 == 1) l = -l;
            if ((j % 2 == 1) ^ $urandom_range(0, 1)) r = -r;
          end
          2: begin
            tp = NTAP - 1 - (j % NTAP);
            l  = (coef_rom[ph][tp] >= 0) ? big : -big;
            r  = (coef_rom[ph][tp] >= 0) ? -big : big;
            if ($urandom_range(0, 7) == 0) l = S_MIN;
          end
          3: begin
            l = 24'($urandom_range(0, 511)) - 24'd256;
            r = 24'($urandom_range(0, 511)) - 24'd256;
          end
          4: begin
            l = pick_extreme();
            r = pick_extreme();
          end
          default: begin
            l = 24'($urandom);
            r = -l;
          end
        endcase
        queue_pair(l, r);
        n_items++;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_pairs.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_peaks.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (expected_peaks.size() != 0) begin
      mismatches += expected_peaks.size();
      $display("%0d true_peak transactions never arrived", expected_peaks.size());
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
